// ----- sv/wsfb_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfb_pkg
// Shared types, constants and helpers for the masked client frame builder.
// ----------------------------------------------------------------------------
package wsfb_pkg;

    localparam int LENGTH_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int FRAME_LEN_W         = 32;
    localparam int STEP_W              = 4;

    localparam logic [31:0] MASK_KEY_RESET = 32'h1234_5678;
    localparam logic [7:0]  MASK_BIT       = 8'h80;
    localparam logic [31:0] LEN_SHORT_MAX  = 32'd125;
    localparam logic [31:0] LEN_MID_MAX    = 32'd65535;
    localparam logic [7:0]  LEN_CODE_16    = 8'd126;
    localparam logic [7:0]  LEN_CODE_64    = 8'd127;
    localparam logic [7:0]  TYPE_DEFAULT   = 8'd129;

    localparam logic [STEP_W-1:0] HDR_LEN_SHORT = 4'd2;
    localparam logic [STEP_W-1:0] HDR_LEN_MID   = 4'd4;
    localparam logic [STEP_W-1:0] HDR_LEN_LONG  = 4'd10;
    localparam logic [STEP_W-1:0] KEY_BYTES     = 4'd4;

    typedef enum logic {
        REQ_START   = 1'b0,
        REQ_PAYLOAD = 1'b1
    } req_kind_t;

    typedef enum logic {
        CMD_HEADER = 1'b0,
        CMD_DATA   = 1'b1
    } cmd_kind_t;

    typedef enum logic [1:0] {
        FORM_SHORT = 2'd0,
        FORM_MID   = 2'd1,
        FORM_LONG  = 2'd2
    } len_form_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [7:0]             data;
        logic [FRAME_LEN_W-1:0] len;
        len_form_t              form;
        logic [1:0]             phase;
        logic                   done;
    } cmd_t;

    function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
        logic [1:0] sel;
        sel = 2'd3 - idx;
        return key[{sel, 3'b000} +: 8];
    endfunction

endpackage

// ----- sv/wsfb_queue.sv -----
// ----------------------------------------------------------------------------
// wsfb_queue
// Short command queue between the classifier and the byte emitter.
// ----------------------------------------------------------------------------
module wsfb_queue #(
    parameter int DEPTH = wsfb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  wsfb_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output wsfb_pkg::cmd_t head_cmd
);
    import wsfb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- sv/wsfb_front.sv -----
// ----------------------------------------------------------------------------
// wsfb_front
// Accepts request transactions, tracks the open frame and turns each start
// request, and each payload request of an open frame, into a header or data command for the emitter.
// ----------------------------------------------------------------------------
module wsfb_front #(
    parameter int LENGTH_BITS = wsfb_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  wsfb_pkg::req_kind_t              req_type,
    input  logic [7:0]                       frame_type,
    input  logic [wsfb_pkg::FRAME_LEN_W-1:0] frame_length,
    input  logic [7:0]                       payload_byte,
    input  logic                             queue_full,
    output logic                             push,
    output wsfb_pkg::cmd_t                   push_cmd
);
    import wsfb_pkg::*;

    localparam int LEN_W = (LENGTH_BITS < FRAME_LEN_W) ? LENGTH_BITS : FRAME_LEN_W;
    localparam logic [FRAME_LEN_W-1:0] LEN_MASK = (LENGTH_BITS >= FRAME_LEN_W) ?
        {FRAME_LEN_W{1'b1}} : FRAME_LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

    logic [LEN_W-1:0] bytes_remaining_reg, bytes_remaining_next;
    logic [1:0]       mask_phase_reg, mask_phase_next;

    logic [FRAME_LEN_W-1:0] len_masked;
    logic                   accept;
    logic                   frame_open;

    assign in_ready   = !queue_full;
    assign accept     = in_valid && in_ready;
    assign len_masked = frame_length & LEN_MASK;
    assign frame_open = (bytes_remaining_reg != '0);

    always_comb
    begin
        bytes_remaining_next = bytes_remaining_reg;
        mask_phase_next      = mask_phase_reg;
        push                 = 1'b0;
        push_cmd             = '0;
        case (req_type)
            REQ_START:
            begin
                push_cmd.kind  = CMD_HEADER;
                push_cmd.data  = (frame_type == 8'd0) ? TYPE_DEFAULT : frame_type;
                push_cmd.len   = len_masked;
                push_cmd.phase = 2'd0;
                push_cmd.done  = (len_masked == '0);
                if (len_masked <= LEN_SHORT_MAX)
                begin
                    push_cmd.form = FORM_SHORT;
                end
                else if (len_masked <= LEN_MID_MAX)
                begin
                    push_cmd.form = FORM_MID;
                end
                else
                begin
                    push_cmd.form = FORM_LONG;
                end
                if (accept)
                begin
                    push                 = 1'b1;
                    bytes_remaining_next = len_masked[LEN_W-1:0];
                    mask_phase_next      = 2'd0;
                end
            end
            REQ_PAYLOAD:
            begin
                push_cmd.kind  = CMD_DATA;
                push_cmd.data  = payload_byte;
                push_cmd.form  = FORM_SHORT;
                push_cmd.phase = mask_phase_reg;
                push_cmd.done  = (bytes_remaining_reg == LEN_W'(1));
                if (accept && frame_open)
                begin
                    push                 = 1'b1;
                    bytes_remaining_next = bytes_remaining_reg - 1'b1;
                    mask_phase_next      = mask_phase_reg + 1'b1;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_remaining_reg <= '0;
            mask_phase_reg      <= '0;
        end
        else
        begin
            bytes_remaining_reg <= bytes_remaining_next;
            mask_phase_reg      <= mask_phase_next;
        end
    end

endmodule

// ----- sv/wsfb_back.sv -----
// ----------------------------------------------------------------------------
// wsfb_back
// Emits the bytes of each queued command into a registered output stage:
// the full header for a header command, one masked byte for a data command.
// ----------------------------------------------------------------------------
module wsfb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [31:0]    mask_key,
    input  logic           head_valid,
    input  wsfb_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           out_last,
    output logic           out_done
);
    import wsfb_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              out_done_reg;

    logic [STEP_W-1:0] hdr_len;
    logic [STEP_W-1:0] ext_sel;
    logic [STEP_W-1:0] key_sel;
    logic [63:0]       len_wide;
    logic [7:0]        code_byte;
    logic [7:0]        gen_byte;
    logic              gen_last;
    logic              advance;

    assign len_wide = {32'd0, head_cmd.len};
    assign ext_sel  = hdr_len - 1'b1 - step_reg;
    assign key_sel  = step_reg - hdr_len;
    assign advance  = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        case (head_cmd.form)
            FORM_SHORT:
            begin
                hdr_len   = HDR_LEN_SHORT;
                code_byte = MASK_BIT | head_cmd.len[7:0];
            end
            FORM_MID:
            begin
                hdr_len   = HDR_LEN_MID;
                code_byte = MASK_BIT | LEN_CODE_16;
            end
            FORM_LONG:
            begin
                hdr_len   = HDR_LEN_LONG;
                code_byte = MASK_BIT | LEN_CODE_64;
            end
            default:
            begin
                hdr_len   = HDR_LEN_SHORT;
                code_byte = MASK_BIT;
            end
        endcase
    end

    always_comb
    begin
        case (head_cmd.kind)
            CMD_HEADER:
            begin
                gen_last = (step_reg == hdr_len + KEY_BYTES - 1'b1);
                if (step_reg == '0)
                begin
                    gen_byte = head_cmd.data;
                end
                else if (step_reg == STEP_W'(1))
                begin
                    gen_byte = code_byte;
                end
                else if (step_reg < hdr_len)
                begin
                    gen_byte = len_wide[{ext_sel[2:0], 3'b000} +: 8];
                end
                else
                begin
                    gen_byte = key_byte(mask_key, key_sel[1:0]);
                end
            end
            CMD_DATA:
            begin
                gen_last = 1'b1;
                gen_byte = head_cmd.data ^ key_byte(mask_key, head_cmd.phase);
            end
            default:
            begin
                gen_last = 1'b1;
                gen_byte = '0;
            end
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (gen_last)
            begin
                pop       = 1'b1;
                step_next = '0;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= gen_byte;
            out_last_reg <= gen_last;
            out_done_reg <= gen_last && head_cmd.done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_done  = out_done_reg;

endmodule

// ----- sv/websocket_client_frame_builder_unit.sv -----
// ----------------------------------------------------------------------------
// websocket_client_frame_builder_unit
// Builds masked client frames as a byte stream from start and payload
// requests. A request is accepted when the four-entry command queue has room.
// A request passes through the command queue and the registered output stage
// before its first byte is presented on the output.
// Payload bytes leave one byte per cycle while the output is not stalled; a start
// request holds the emitter for its 6, 8 or 14 header bytes.
// Reset clears the open frame and the queue and loads the key 0x12345678.
// ----------------------------------------------------------------------------
module websocket_client_frame_builder_unit #(
    parameter int LENGTH_BITS = wsfb_pkg::LENGTH_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = wsfb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // frame_type[7:0], frame_length[39:8], payload_byte[47:40]
    input  logic        s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,
    output logic        m_tuser,   // frame_done[0]
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);
    import wsfb_pkg::*;

    logic [31:0] mask_key_reg, mask_key_next;
    logic        queue_full;
    logic        push;
    cmd_t        push_cmd;
    logic        pop;
    logic        head_valid;
    cmd_t        head_cmd;
    req_kind_t   req_type;

    assign req_type      = req_kind_t'(s_tuser);
    assign mask_key_next = cfg_we ? cfg_wdata : mask_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_key_reg <= MASK_KEY_RESET;
        end
        else
        begin
            mask_key_reg <= mask_key_next;
        end
    end

    wsfb_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .req_type     (req_type),
        .frame_type   (s_tdata[7:0]),
        .frame_length (s_tdata[39:8]),
        .payload_byte (s_tdata[47:40]),
        .queue_full   (queue_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    wsfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    wsfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mask_key   (mask_key_reg),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast),
        .out_done   (m_tuser)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the masked client frame builder. A short table of directed
// transactions covers the length forms, the type substitution, zero-length
// frames, dropped payload and abandoned frames. Random frames follow under
// several masking keys. Typed table rows are checked against their own bytes,
// every other output against a behavioral encoder updated at each accepted
// input transaction; the sender idles in bursts and the receiver stalls on
// patterns of its own, including one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import wsfb_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_SETTLE  = 16;
    localparam int END_SETTLE   = 32;
    localparam int PHASE_ITEMS  = 50;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        RX_ALWAYS      = 2'd0,
        RX_HALF        = 2'd1,
        RX_MOSTLY      = 2'd2,
        RX_EVERY_THIRD = 2'd3
    } rx_mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       frame_done;
    } wire_byte_t;

    typedef struct packed {
        logic         typed;
        req_kind_t    req;
        logic [7:0]   ftype;
        logic [31:0]  flen;
        logic [7:0]   pbyte;
        logic [3:0]   n_typed;
        logic         done_typed;
        logic [111:0] typed_bytes;
    } stim_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;

    logic [31:0] enc_key       = MASK_KEY_RESET;
    logic [1:0]  enc_phase     = 2'd0;
    logic [31:0] enc_remaining = '0;

    wire_byte_t  pred_q [$];
    wire_byte_t  wire_q [$];
    stim_row_t   dir_table [$];

    int  errors        = 0;
    int  cycle_count   = 0;
    int  items_sent    = 0;
    int  bytes_checked = 0;
    int  keys_loaded   = 0;
    int  frames_opened = 0;
    int  hold_token    = 0;
    int  burst_left    = 0;
    bit  valid_up      = 1'b0;
    bit  no_gaps       = 1'b0;

    websocket_client_frame_builder_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("websocket_client_frame_builder_unit test failed");
            $finish;
        end
    end

    function automatic void frame_encode(input req_kind_t req, input logic [7:0] ftype,
                                         input logic [31:0] flen, input logic [7:0] pbyte);
        logic [7:0] hdr [$];
        wire_byte_t wb;
        int         i;
        hdr = {};
        pred_q = {};
        if (req == REQ_START)
        begin
            hdr.push_back((ftype == 8'd0) ? TYPE_DEFAULT : ftype);
            if (flen <= LEN_SHORT_MAX)
            begin
                hdr.push_back(flen[7:0] | MASK_BIT);
            end
            else if (flen <= LEN_MID_MAX)
            begin
                hdr.push_back(LEN_CODE_16 | MASK_BIT);
                hdr.push_back(flen[15:8]);
                hdr.push_back(flen[7:0]);
            end
            else
            begin
                hdr.push_back(LEN_CODE_64 | MASK_BIT);
                for (i = 7; i >= 0; i--)
                    hdr.push_back((i >= 4) ? 8'h00 : flen[8*i +: 8]);
            end
            for (i = 0; i < 4; i++)
                hdr.push_back(enc_key[8*(3-i) +: 8]);
            for (i = 0; i < hdr.size(); i++)
            begin
                wb.out_byte    = hdr[i];
                wb.last_of_run = (i == hdr.size() - 1);
                wb.frame_done  = wb.last_of_run && (flen == 32'd0);
                pred_q.push_back(wb);
            end
            enc_phase     = 2'd0;
            enc_remaining = flen;
        end
        else if (enc_remaining != 32'd0)
        begin
            wb.out_byte    = pbyte ^ enc_key[8*(2'd3 - enc_phase) +: 8];
            enc_remaining  = enc_remaining - 32'd1;
            enc_phase      = enc_phase + 2'd1;
            wb.last_of_run = 1'b1;
            wb.frame_done  = (enc_remaining == 32'd0);
            pred_q.push_back(wb);
        end
    endfunction

    function automatic stim_row_t typed_row(input req_kind_t req, input logic [7:0] ftype,
                                            input logic [31:0] flen, input logic [7:0] pbyte,
                                            input logic [3:0] n, input logic done,
                                            input logic [111:0] bytes);
        stim_row_t r;
        r = '{1'b1, req, ftype, flen, pbyte, n, done, bytes};
        return r;
    endfunction

    function automatic stim_row_t free_row(input req_kind_t req, input logic [7:0] ftype,
                                           input logic [31:0] flen, input logic [7:0] pbyte);
        stim_row_t r;
        r = '{1'b0, req, ftype, flen, pbyte, 4'd0, 1'b0, 112'd0};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input wire_byte_t exp_b,
                                   input wire_byte_t act_b);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display({"mismatch (%s): expected byte=%02h last=%0b done=%0b, ",
                      "got byte=%02h last=%0b done=%0b"},
                     what, exp_b.out_byte, exp_b.last_of_run, exp_b.frame_done,
                     act_b.out_byte, act_b.last_of_run, act_b.frame_done);
    endtask

    task automatic offer_item(input stim_row_t row, output int n_res);
        wire_byte_t wb;
        int         k;
        int         gap;
        s_tvalid <= 1'b1;
        s_tuser  <= row.req;
        s_tdata  <= {row.pbyte, row.flen, row.ftype};
        valid_up = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (row.req == REQ_START)
            frames_opened++;
        frame_encode(row.req, row.ftype, row.flen, row.pbyte);
        if (row.typed)
        begin
            n_res = row.n_typed;
            for (k = 0; k < n_res; k++)
            begin
                wb.out_byte    = row.typed_bytes[8*(n_res-1-k) +: 8];
                wb.last_of_run = (k == n_res - 1);
                wb.frame_done  = wb.last_of_run && row.done_typed;
                wire_q.push_back(wb);
            end
        end
        else
        begin
            n_res = pred_q.size();
            foreach (pred_q[k])
                wire_q.push_back(pred_q[k]);
        end
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                valid_up = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_idle();
        if (valid_up)
        begin
            s_tvalid <= 1'b0;
            valid_up = 1'b0;
        end
        while (wire_q.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic load_key(input logic [31:0] key);
        cfg_we    <= 1'b1;
        cfg_wdata <= key;
        @(posedge clk);
        cfg_we  <= 1'b0;
        enc_key = key;
        keys_loaded++;
    endtask

    task automatic run_random_phase(input int target);
        int          produced;
        int          n;
        int          npay;
        int          k;
        logic [31:0] flen;
        logic [7:0]  ftype;
        produced = 0;
        while (produced < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                offer_item(free_row(REQ_PAYLOAD, 8'($urandom), $urandom, 8'($urandom)), n);
                produced += (n > 0) ? 1 : 0;
            end
            else
            begin
                ftype = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: flen = $urandom_range(0, 12);
                    5:             flen = $urandom_range(120, 130);
                    6:             flen = $urandom_range(65530, 65540);
                    7:             flen = $urandom_range(65536, 32'hFFFF_FFFF);
                    8:             flen = $urandom_range(13, 40);
                    default:       flen = 32'd0;
                endcase
                if (flen <= 32'd40)
                begin
                    npay = flen;
                    case ($urandom_range(0, 5))
                        0:       npay = $urandom_range(0, flen);
                        1:       npay = flen + $urandom_range(1, 3);
                        default: npay = flen;
                    endcase
                end
                else
                begin
                    npay = $urandom_range(0, 12);
                end
                offer_item(free_row(REQ_START, ftype, flen, 8'($urandom)), n);
                produced++;
                for (k = 0; k < npay; k++)
                begin
                    offer_item(free_row(REQ_PAYLOAD, 8'($urandom), $urandom, 8'($urandom)), n);
                    produced += (n > 0) ? 1 : 0;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        wire_byte_t act_b;
        wire_byte_t exp_b;
        if (rst_n && m_tvalid && m_tready)
        begin
            act_b = '{m_tdata, m_tlast, m_tuser};
            if (wire_q.size() == 0)
            begin
                report_mismatch("unexpected", '0, act_b);
            end
            else
            begin
                exp_b = wire_q.pop_front();
                bytes_checked++;
                if (act_b.out_byte != exp_b.out_byte || act_b.last_of_run != exp_b.last_of_run
                    || act_b.frame_done != exp_b.frame_done)
                    report_mismatch("field", exp_b, act_b);
            end
        end
    end

    initial
    begin : rx_pacing
        rx_mode_t mode;
        int       span;
        int       tick;
        int       hold_seen;
        hold_seen = 0;
        forever
        begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 120);
            for (tick = 0; tick < span; tick++)
            begin
                @(posedge clk);
                if (hold_token != hold_seen)
                begin
                    hold_seen = hold_token;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    RX_ALWAYS:      m_tready <= 1'b1;
                    RX_HALF:        m_tready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY:      m_tready <= ($urandom_range(0, 3) != 0);
                    RX_EVERY_THIRD: m_tready <= (tick % 3 == 0);
                    default:        m_tready <= 1'b1;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int n;
        dir_table.push_back(typed_row(REQ_PAYLOAD, 8'h00, 32'd0, 8'hAA, 4'd0, 1'b0, 112'h0));
        dir_table.push_back(typed_row(REQ_START, 8'h00, 32'd0, 8'h00, 4'd6, 1'b1,
                                      112'h81_80_12_34_56_78));
        dir_table.push_back(typed_row(REQ_PAYLOAD, 8'h00, 32'd0, 8'h55, 4'd0, 1'b0, 112'h0));
        dir_table.push_back(typed_row(REQ_START, 8'hFF, 32'd125, 8'h00, 4'd6, 1'b0,
                                      112'hFF_FD_12_34_56_78));
        dir_table.push_back(typed_row(REQ_PAYLOAD, 8'h00, 32'd0, 8'h00, 4'd1, 1'b0, 112'h12));
        dir_table.push_back(typed_row(REQ_PAYLOAD, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 4'd1, 1'b0,
                                      112'hCB));
        dir_table.push_back(free_row(REQ_PAYLOAD, 8'h00, 32'd0, 8'h0F));
        dir_table.push_back(typed_row(REQ_START, 8'h82, 32'd1, 8'h00, 4'd6, 1'b0,
                                      112'h82_81_12_34_56_78));
        dir_table.push_back(typed_row(REQ_PAYLOAD, 8'h00, 32'd0, 8'hA5, 4'd1, 1'b1, 112'hB7));
        dir_table.push_back(typed_row(REQ_START, 8'h01, 32'd126, 8'h00, 4'd8, 1'b0,
                                      112'h01_FE_00_7E_12_34_56_78));
        dir_table.push_back(free_row(REQ_PAYLOAD, 8'h00, 32'd0, 8'hFF));
        dir_table.push_back(typed_row(REQ_START, 8'h88, 32'd65535, 8'h00, 4'd8, 1'b0,
                                      112'h88_FE_FF_FF_12_34_56_78));
        dir_table.push_back(typed_row(REQ_START, 8'h89, 32'd65536, 8'h00, 4'd14, 1'b0,
                                      112'h89_FF_00_00_00_00_00_01_00_00_12_34_56_78));
        dir_table.push_back(typed_row(REQ_START, 8'h8A, 32'hFFFF_FFFF, 8'hFF, 4'd14, 1'b0,
                                      112'h8A_FF_00_00_00_00_FF_FF_FF_FF_12_34_56_78));
        dir_table.push_back(free_row(REQ_PAYLOAD, 8'h00, 32'd0, 8'h00));
        dir_table.push_back(free_row(REQ_PAYLOAD, 8'h00, 32'd0, 8'hFF));
        dir_table.push_back(free_row(REQ_PAYLOAD, 8'h00, 32'd0, 8'h5A));
        dir_table.push_back(free_row(REQ_PAYLOAD, 8'h00, 32'd0, 8'hC3));
        dir_table.push_back(typed_row(REQ_START, 8'h00, 32'd2, 8'h00, 4'd6, 1'b0,
                                      112'h81_82_12_34_56_78));
        dir_table.push_back(free_row(REQ_PAYLOAD, 8'h00, 32'd0, 8'h3C));
        dir_table.push_back(free_row(REQ_PAYLOAD, 8'h00, 32'd0, 8'h99));
        dir_table.push_back(typed_row(REQ_PAYLOAD, 8'h00, 32'd0, 8'h77, 4'd0, 1'b0, 112'h0));
        dir_table.push_back(free_row(REQ_START, 8'h80, 32'd3, 8'h00));
        dir_table.push_back(free_row(REQ_PAYLOAD, 8'h00, 32'd0, 8'h6E));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[r])
            offer_item(dir_table[r], n);

        // The frame opened at the end of the table is still open here, so the
        // next payload transactions are masked with the newly loaded key.
        wait_idle();
        load_key(32'h0000_0000);
        offer_item(free_row(REQ_PAYLOAD, 8'h00, 32'd0, 8'hE1), n);
        offer_item(free_row(REQ_PAYLOAD, 8'h00, 32'd0, 8'h1E), n);
        run_random_phase(PHASE_ITEMS);

        wait_idle();
        load_key(32'hFFFF_FFFF);
        run_random_phase(PHASE_ITEMS);

        wait_idle();
        load_key($urandom);
        no_gaps = 1'b1;
        hold_token <= hold_token + 1;
        run_random_phase(PHASE_ITEMS);
        no_gaps = 1'b0;

        wait_idle();
        load_key($urandom);
        run_random_phase(PHASE_ITEMS);

        wait_idle();
        load_key(MASK_KEY_RESET);
        run_random_phase(PHASE_ITEMS);

        wait_idle();
        load_key($urandom);
        run_random_phase(PHASE_ITEMS);

        wait_idle();
        repeat (END_SETTLE) @(posedge clk);
        if (wire_q.size() != 0)
        begin
            $display("%0d expected output transactions never arrived", wire_q.size());
            errors += wire_q.size();
        end

        $display("sent %0d input transactions opening %0d frames under %0d key settings",
                 items_sent, frames_opened, keys_loaded + 1);
        $display("checked %0d output transactions, %0d mismatches", bytes_checked, errors);
        if (errors == 0)
            $display("websocket_client_frame_builder_unit test passed");
        else
            $display("websocket_client_frame_builder_unit test failed");
        $finish;
    end

endmodule
